// ===== rtl/qjtg_pkg.sv =====
`timescale 1ns / 1ps

package qjtg_pkg;

    // Field widths of the two channels and the configuration word.
    localparam int POS_W      = 16;
    localparam int JOINT_W    = 6;
    localparam int STEP_OUT_W = 6;
    localparam int NCOUNT_W   = 7;

    // Step count limits and reset value.
    localparam logic [NCOUNT_W-1:0] STEP_COUNT_RESET = 7'd48;
    localparam logic [NCOUNT_W-1:0] MIN_STEPS        = 7'd2;
    localparam logic [NCOUNT_W-1:0] MAX_STEPS        = 7'd64;

    // Blend is unsigned Q1.16.
    localparam int BLEND_FRAC = 16;
    localparam int QUOT_W     = BLEND_FRAC + 1;

    // Intermediate widths, sized for a step count of at most 64.
    localparam int N2_W       = 13;
    localparam int K2_W       = 12;
    localparam int K3_W       = 18;
    localparam int KN_W       = 12;
    localparam int POLY_W     = 17;
    localparam int POLY_CALC_W = 19;
    localparam int N5_W       = 31;
    localparam int NUM_W      = 31;
    localparam int DIVIDEND_W = 48;
    localparam int DIV_CNT_W  = 5;
    localparam int MAG_W      = POS_W + 1;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Coefficients of the blend numerator 10N^2 - 15kN + 6k^2.
    localparam logic [POLY_CALC_W-1:0] POLY_C_NN = 19'd10;
    localparam logic [POLY_CALC_W-1:0] POLY_C_KN = 19'd15;
    localparam logic [POLY_CALC_W-1:0] POLY_C_KK = 19'd6;

    // Rounding constant for the final Q1.16 scale.
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (BLEND_FRAC - 1);

    typedef struct packed {
        logic [JOINT_W-1:0]      joint_index;
        logic signed [POS_W-1:0] start_position;
        logic signed [POS_W-1:0] goal_position;
    } in_word_t;

    typedef struct packed {
        logic [JOINT_W-1:0]      joint_id;
        logic [STEP_OUT_W-1:0]   step_number;
        logic signed [POS_W-1:0] waypoint_position;
        logic                    last_waypoint;
    } out_word_t;

    // Request to the shared multiplier.
    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    // Request to the iterative divider.
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [N5_W-1:0]       divisor;
    } div_req_t;

    // Sequencer states.
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_N2    = 14'b00000000000010,
        S_N3    = 14'b00000000000100,
        S_N4    = 14'b00000000001000,
        S_N5    = 14'b00000000010000,
        S_NSAVE = 14'b00000000100000,
        S_K2    = 14'b00000001000000,
        S_K3    = 14'b00000010000000,
        S_KN    = 14'b00000100000000,
        S_POLY  = 14'b00001000000000,
        S_NUM   = 14'b00010000000000,
        S_DIV   = 14'b00100000000000,
        S_DWAIT = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } state_t;

endpackage

// ===== rtl/quintic_joint_trajectory_generator.sv =====
`timescale 1ns / 1ps

// Channel   Signals                         Word
// -------   -----------------------------   ---------------------------------------
// input     in_valid, in_ready, in_data     joint index, start and goal position
// output    out_valid, out_ready, out_data  joint id, step, waypoint, last flag
// config    cfg_valid, cfg_ready, cfg_data  step count N (always ready)
//
// Each waypoint of an input word runs five products on the shared multiplier and
// a restoring divider for the Q1.16 blend.
// Reset clears the sequencer, the output valid and sets N to 48; no clearing pass.
// Input ready is high only while idle. A waypoint waits in the output register
// while the next one is computed; a stalled output holds the sequencer at emit.

module quintic_joint_trajectory_generator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  qjtg_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output qjtg_pkg::out_word_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qjtg_pkg::NCOUNT_W-1:0]       cfg_data
);

    qjtg_pkg::state_t                   state_reg;
    qjtg_pkg::state_t                   state_next;
    logic [qjtg_pkg::NCOUNT_W-1:0]      step_count_reg;
    logic [qjtg_pkg::NCOUNT_W-1:0]      n_eff;
    logic [qjtg_pkg::NCOUNT_W-1:0]      n_reg;
    logic [qjtg_pkg::NCOUNT_W-1:0]      k_reg;
    logic [qjtg_pkg::JOINT_W-1:0]       joint_reg;
    logic signed [qjtg_pkg::POS_W-1:0]  start_reg;
    logic [qjtg_pkg::MAG_W-1:0]         mag_reg;
    logic                               neg_reg;
    logic [qjtg_pkg::N2_W-1:0]          n2_reg;
    logic [qjtg_pkg::N5_W-1:0]          n5_reg;
    logic [qjtg_pkg::K2_W-1:0]          k2_reg;
    logic [qjtg_pkg::K3_W-1:0]          k3_reg;
    logic [qjtg_pkg::POLY_W-1:0]        poly_reg;
    qjtg_pkg::out_word_t                out_reg;
    logic                               out_valid_reg;

    qjtg_pkg::mul_req_t                 mul_req;
    logic [qjtg_pkg::PROD_W-1:0]        prod;
    qjtg_pkg::div_req_t                 div_req;
    logic [qjtg_pkg::QUOT_W-1:0]        quotient;
    logic                               div_done;

    logic                               in_take;
    logic                               out_free;
    logic                               is_last;
    logic signed [qjtg_pkg::MAG_W-1:0]  delta;
    logic [qjtg_pkg::POLY_CALC_W-1:0]   poly_sum;
    logic [qjtg_pkg::PROD_W-1:0]        off_round;
    logic [qjtg_pkg::MAG_W-1:0]         offset;
    logic signed [qjtg_pkg::MAG_W:0]    start_ext;
    logic signed [qjtg_pkg::MAG_W:0]    offset_ext;
    logic signed [qjtg_pkg::MAG_W:0]    pos_wide;

    // Shared multiplier and blend divider.
    qjtg_mul u_mul
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    qjtg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .quotient (quotient),
        .done     (div_done)
    );

    // Handshakes.
    assign in_ready  = (state_reg == qjtg_pkg::S_IDLE);
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign is_last   = (k_reg == (n_reg - 1'b1));

    // Step count clamped to the supported range.
    always_comb
    begin
        priority if (step_count_reg < qjtg_pkg::MIN_STEPS)
        begin
            n_eff = qjtg_pkg::MIN_STEPS;
        end
        else if (step_count_reg > qjtg_pkg::MAX_STEPS)
        begin
            n_eff = qjtg_pkg::MAX_STEPS;
        end
        else
        begin
            n_eff = step_count_reg;
        end
    end

    // Signed span from start to goal.
    assign delta = qjtg_pkg::MAG_W'(in_data.goal_position) -
                   qjtg_pkg::MAG_W'(in_data.start_position);

    // Blend numerator factor 10N^2 - 15kN + 6k^2; the kN product is on the multiplier output.
    assign poly_sum = qjtg_pkg::POLY_C_NN * qjtg_pkg::POLY_CALC_W'(n2_reg)
                    + qjtg_pkg::POLY_C_KK * qjtg_pkg::POLY_CALC_W'(k2_reg)
                    - qjtg_pkg::POLY_C_KN * qjtg_pkg::POLY_CALC_W'(prod[qjtg_pkg::KN_W-1:0]);

    // Scaled offset rounded to nearest, then applied with the sign of the span.
    assign off_round  = prod + qjtg_pkg::ROUND_HALF;
    assign offset     = off_round[qjtg_pkg::BLEND_FRAC +: qjtg_pkg::MAG_W];
    assign start_ext  = (qjtg_pkg::MAG_W + 1)'(start_reg);
    assign offset_ext = $signed({1'b0, offset});
    assign pos_wide   = neg_reg ? (start_ext - offset_ext) : (start_ext + offset_ext);

    // Multiplier operand selection per sequencer step.
    always_comb
    begin
        mul_req = '0;
        unique case (state_reg)
            qjtg_pkg::S_N2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = qjtg_pkg::MUL_A_W'(n_reg);
                mul_req.b  = qjtg_pkg::MUL_B_W'(n_reg);
            end
            qjtg_pkg::S_N3, qjtg_pkg::S_N4, qjtg_pkg::S_N5:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = prod[qjtg_pkg::MUL_A_W-1:0];
                mul_req.b  = qjtg_pkg::MUL_B_W'(n_reg);
            end
            qjtg_pkg::S_K2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = qjtg_pkg::MUL_A_W'(k_reg);
                mul_req.b  = qjtg_pkg::MUL_B_W'(k_reg);
            end
            qjtg_pkg::S_K3:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = prod[qjtg_pkg::MUL_A_W-1:0];
                mul_req.b  = qjtg_pkg::MUL_B_W'(k_reg);
            end
            qjtg_pkg::S_KN:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = qjtg_pkg::MUL_A_W'(k_reg);
                mul_req.b  = qjtg_pkg::MUL_B_W'(n_reg);
            end
            qjtg_pkg::S_NUM:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = qjtg_pkg::MUL_A_W'(k3_reg);
                mul_req.b  = qjtg_pkg::MUL_B_W'(poly_reg);
            end
            qjtg_pkg::S_DWAIT:
            begin
                mul_req.en = div_done;
                mul_req.a  = qjtg_pkg::MUL_A_W'(mag_reg);
                mul_req.b  = qjtg_pkg::MUL_B_W'(quotient);
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    // Divider launch: numerator scaled to Q16 plus half the divisor for rounding.
    always_comb
    begin
        div_req.start    = (state_reg == qjtg_pkg::S_DIV);
        div_req.divisor  = n5_reg;
        div_req.dividend = (qjtg_pkg::DIVIDEND_W'(prod[qjtg_pkg::NUM_W-1:0]) << qjtg_pkg::BLEND_FRAC)
                         + qjtg_pkg::DIVIDEND_W'(n5_reg >> 1);
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qjtg_pkg::S_IDLE:  if (in_take) state_next = qjtg_pkg::S_N2;
            qjtg_pkg::S_N2:    state_next = qjtg_pkg::S_N3;
            qjtg_pkg::S_N3:    state_next = qjtg_pkg::S_N4;
            qjtg_pkg::S_N4:    state_next = qjtg_pkg::S_N5;
            qjtg_pkg::S_N5:    state_next = qjtg_pkg::S_NSAVE;
            qjtg_pkg::S_NSAVE: state_next = qjtg_pkg::S_K2;
            qjtg_pkg::S_K2:    state_next = qjtg_pkg::S_K3;
            qjtg_pkg::S_K3:    state_next = qjtg_pkg::S_KN;
            qjtg_pkg::S_KN:    state_next = qjtg_pkg::S_POLY;
            qjtg_pkg::S_POLY:  state_next = qjtg_pkg::S_NUM;
            qjtg_pkg::S_NUM:   state_next = qjtg_pkg::S_DIV;
            qjtg_pkg::S_DIV:   state_next = qjtg_pkg::S_DWAIT;
            qjtg_pkg::S_DWAIT: if (div_done) state_next = qjtg_pkg::S_EMIT;
            qjtg_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = is_last ? qjtg_pkg::S_IDLE : qjtg_pkg::S_K2;
                end
            end
            default:           state_next = qjtg_pkg::S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= qjtg_pkg::S_IDLE;
            step_count_reg <= qjtg_pkg::STEP_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                step_count_reg <= cfg_data;
            end
            if ((state_reg == qjtg_pkg::S_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Per-word and per-waypoint working registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            qjtg_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    joint_reg <= in_data.joint_index;
                    start_reg <= in_data.start_position;
                    neg_reg   <= delta[qjtg_pkg::MAG_W-1];
                    mag_reg   <= delta[qjtg_pkg::MAG_W-1] ? qjtg_pkg::MAG_W'(-delta)
                                                          : qjtg_pkg::MAG_W'(delta);
                    n_reg     <= n_eff;
                    k_reg     <= qjtg_pkg::NCOUNT_W'(1);
                end
            end
            qjtg_pkg::S_N3:
            begin
                n2_reg <= prod[qjtg_pkg::N2_W-1:0];
            end
            qjtg_pkg::S_NSAVE:
            begin
                n5_reg <= prod[qjtg_pkg::N5_W-1:0];
            end
            qjtg_pkg::S_K3:
            begin
                k2_reg <= prod[qjtg_pkg::K2_W-1:0];
            end
            qjtg_pkg::S_KN:
            begin
                k3_reg <= prod[qjtg_pkg::K3_W-1:0];
            end
            qjtg_pkg::S_POLY:
            begin
                poly_reg <= poly_sum[qjtg_pkg::POLY_W-1:0];
            end
            qjtg_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_reg.joint_id          <= joint_reg;
                    out_reg.step_number       <= k_reg[qjtg_pkg::STEP_OUT_W-1:0];
                    out_reg.waypoint_position <= pos_wide[qjtg_pkg::POS_W-1:0];
                    out_reg.last_waypoint     <= is_last;
                    k_reg                     <= k_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/qjtg_mul.sv =====
`timescale 1ns / 1ps

module qjtg_mul
(
    input  logic                          clk,
    input  qjtg_pkg::mul_req_t            req,
    output logic [qjtg_pkg::PROD_W-1:0]   prod
);

    logic [qjtg_pkg::PROD_W-1:0] prod_reg;

    // One registered product per issued request; the result holds until the next one.
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= qjtg_pkg::PROD_W'(req.a) * qjtg_pkg::PROD_W'(req.b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/qjtg_div.sv =====
`timescale 1ns / 1ps

module qjtg_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  qjtg_pkg::div_req_t            req,
    output logic [qjtg_pkg::QUOT_W-1:0]   quotient,
    output logic                          done
);

    logic [qjtg_pkg::DIVIDEND_W-1:0] rem_reg;
    logic [qjtg_pkg::DIVIDEND_W-1:0] dsr_reg;
    logic [qjtg_pkg::QUOT_W-1:0]     quot_reg;
    logic [qjtg_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic                            fits;
    logic [qjtg_pkg::DIVIDEND_W-1:0] diff;

    // Trial subtraction of the shifted divisor.
    assign fits = (rem_reg >= dsr_reg);
    assign diff = rem_reg - dsr_reg;

    // Iteration counter: one quotient bit per cycle, most significant first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= qjtg_pkg::DIV_CNT_W'(qjtg_pkg::QUOT_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Restoring division datapath.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.dividend;
            dsr_reg  <= qjtg_pkg::DIVIDEND_W'(req.divisor) << (qjtg_pkg::QUOT_W - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= diff;
            end
            quot_reg <= {quot_reg[qjtg_pkg::QUOT_W-2:0], fits};
            dsr_reg  <= dsr_reg >> 1;
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule
